// File: rtl/core/polyline_point_snap_core_defines.svh
// Assertion macros shared by the polyline snap RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef POLYLINE_POINT_SNAP_CORE_DEFINES_SVH
`define POLYLINE_POINT_SNAP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pps_pkg.sv
// Shared types and constants of the polyline point snap core.
// No dependencies; imported by every module of the block.
package pps_pkg;

    // Default sizes of the path store and the coordinate format.
    localparam int MAX_POINTS_DEF  = 256;
    localparam int COORD_BITS_DEF  = 32;

    // Fixed field widths of the transaction payloads.
    localparam int FLD_W     = 32;
    localparam int IDX_W     = 8;
    localparam int DIST_W    = 64;
    localparam int PC_W      = 9;
    localparam int CFG_DW    = 31;
    localparam int CFG_IDX_W = 1;

    // Fraction bits of the projection parameter.
    localparam int FRAC_BITS = 30;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b1;

    // Request type codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        point_index;
        logic signed [FLD_W-1:0] coord_x;
        logic signed [FLD_W-1:0] coord_y;
        logic signed [FLD_W-1:0] coord_z;
    } t_req;

    typedef struct packed {
        logic                    found;
        logic signed [FLD_W-1:0] snap_x;
        logic signed [FLD_W-1:0] snap_y;
        logic signed [FLD_W-1:0] snap_z;
        logic [DIST_W-1:0]       distance_sq;
    } t_rsp;

    // Status of the segment unit as seen by the controller.
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } t_seg_stat;

endpackage

// File: rtl/core/pps_path_mem.sv
// Path point store: one write port and one registered read port.
// Depends on pps_pkg for the default depth and data width.
module pps_path_mem
    import pps_pkg::*;
#(
    parameter int DEPTH = MAX_POINTS_DEF,
    parameter int AW    = 8,
    parameter int DATAW = 3 * COORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [DATAW-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [DATAW-1:0] o_rdata
);

    logic [DATAW-1:0] r_mem [DEPTH];
    logic [DATAW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, enabled by i_re.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/pps_seg_unit.sv
// Segment unit: projects the query point onto one segment with a shared
// multiplier and a bit-serial divider. Depends on pps_pkg.
module pps_seg_unit
    import pps_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [CW-1:0] i_a [3],
    input  logic signed [CW-1:0] i_b [3],
    input  logic signed [CW-1:0] i_p [3],
    output t_seg_stat            o_stat,
    output logic [DIST_W-1:0]    o_dist,
    output logic signed [CW-1:0] o_prj [3]
);

    localparam int MW = (CW + 2 > 32) ? CW + 2 : 32;
    localparam int PW = 2 * MW;
    localparam int DW = 2 * CW + 4;
    localparam int QW = FRAC_BITS + 1;
    localparam logic [2:0] K_DOT_LAST = 3'd5;
    localparam logic [2:0] K_CMP_LAST = 3'd2;
    localparam logic [2:0] K_LEN_BASE = 3'd3;
    localparam logic [4:0] J_LAST     = 5'(FRAC_BITS);

    typedef enum logic [10:0] {
        SG_IDLE = 11'b00000000001,
        SG_DIFF = 11'b00000000010,
        SG_DOT  = 11'b00000000100,
        SG_DOTW = 11'b00000001000,
        SG_CHK  = 11'b00000010000,
        SG_DIV  = 11'b00000100000,
        SG_PRJ  = 11'b00001000000,
        SG_PRJW = 11'b00010000000,
        SG_DST  = 11'b00100000000,
        SG_DSTW = 11'b01000000000,
        SG_DONE = 11'b10000000000
    } t_sg_state;

    typedef enum logic [1:0] {
        PH_DOT = 2'd0,
        PH_LEN = 2'd1,
        PH_PRJ = 2'd2,
        PH_DST = 2'd3
    } t_ph;

    t_sg_state r_state, n_state;
    logic [2:0] r_k;
    logic [4:0] r_j;
    logic signed [CW:0] r_d [3];
    logic signed [CW:0] r_v [3];
    logic signed [DW-1:0] r_dot, r_len;
    logic [DW:0] r_rem;
    logic [QW-1:0] r_q;
    logic r_hit;

    // Product pipeline register and its tag.
    logic signed [PW-1:0] r_prod;
    logic r_pv, r_pneg;
    t_ph r_ph;
    logic [1:0] r_pk;
    logic signed [CW-1:0] r_pa;

    logic signed [CW-1:0] r_prj [3];
    logic [DIST_W-1:0] r_dist;
    logic r_sat;

    // Issue side signals.
    logic iss;
    t_ph ph;
    logic [1:0] c;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [CW+1:0] dw, dmag;
    logic signed [CW:0] ediff;

    // Divider step and segment checks.
    logic [DW:0] den, rem_s;
    logic div_ge, reject;

    // Projection rounding.
    logic [PW-1:0] rnd;
    logic [CW:0] off;
    logic signed [CW+1:0] psum;
    logic [DIST_W:0] dsum;

    // Select the component and operation issued to the multiplier.
    always_comb begin
        iss = 1'b0;
        ph  = PH_DOT;
        c   = r_k[1:0];
        unique case (r_state)
            SG_DOT: begin
                iss = 1'b1;
                if (r_k < K_LEN_BASE) begin
                    ph = PH_DOT;
                end else begin
                    ph = PH_LEN;
                    c  = 2'(r_k - K_LEN_BASE);
                end
            end
            SG_PRJ: begin
                iss = 1'b1;
                ph  = PH_PRJ;
            end
            SG_DST: begin
                iss = 1'b1;
                ph  = PH_DST;
            end
            default: begin
                iss = 1'b0;
            end
        endcase
    end

    // Operands of the shared multiplier.
    always_comb begin
        dw    = (CW+2)'(r_d[c]);
        dmag  = (dw < 0) ? -dw : dw;
        ediff = (CW+1)'(i_p[c]) - (CW+1)'(r_prj[c]);
        unique case (ph)
            PH_DOT: begin
                mul_a = MW'(r_v[c]);
                mul_b = MW'(r_d[c]);
            end
            PH_LEN: begin
                mul_a = MW'(r_d[c]);
                mul_b = MW'(r_d[c]);
            end
            PH_PRJ: begin
                mul_a = MW'(dmag);
                mul_b = MW'(signed'({1'b0, r_q}));
            end
            default: begin
                mul_a = MW'(ediff);
                mul_b = MW'(ediff);
            end
        endcase
    end

    // Divider step: one quotient bit per cycle.
    always_comb begin
        den    = {1'b0, r_len};
        rem_s  = (r_j == '0) ? r_rem : {r_rem[DW-1:0], 1'b0};
        div_ge = (rem_s >= den);
        reject = (r_len == '0) || (r_dot < 0) || (r_dot > r_len);
    end

    // Rounded offset along the segment and the projected coordinate.
    always_comb begin
        rnd  = r_prod + PW'(64'd1 << (FRAC_BITS - 1));
        off  = rnd[FRAC_BITS +: CW+1];
        psum = (CW+2)'(r_pa) + (r_pneg ? -(CW+2)'(signed'({1'b0, off}))
                                        : (CW+2)'(signed'({1'b0, off})));
        dsum = {1'b0, r_dist} + {1'b0, r_prod[DIST_W-1:0]};
    end

    // Sequencer transitions.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SG_IDLE: if (i_start) n_state = SG_DIFF;
            SG_DIFF: n_state = SG_DOT;
            SG_DOT:  if (r_k == K_DOT_LAST) n_state = SG_DOTW;
            SG_DOTW: n_state = SG_CHK;
            SG_CHK:  n_state = reject ? SG_DONE : SG_DIV;
            SG_DIV:  if (r_j == J_LAST) n_state = SG_PRJ;
            SG_PRJ:  if (r_k == K_CMP_LAST) n_state = SG_PRJW;
            SG_PRJW: n_state = SG_DST;
            SG_DST:  if (r_k == K_CMP_LAST) n_state = SG_DSTW;
            SG_DSTW: n_state = SG_DONE;
            SG_DONE: n_state = SG_IDLE;
            default: n_state = SG_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SG_IDLE;
            r_k     <= '0;
            r_j     <= '0;
            r_pv    <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= iss;
            if (iss) begin
                r_k <= (n_state == r_state) ? r_k + 3'd1 : '0;
            end else begin
                r_k <= '0;
            end
            if (r_state == SG_DIV) begin
                r_j <= r_j + 5'd1;
            end else begin
                r_j <= '0;
            end
            if (r_state == SG_CHK) begin
                r_hit <= !reject;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        // Differences of the segment end and the query point to its start.
        if (r_state == SG_DIFF) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= (CW+1)'(i_b[i]) - (CW+1)'(i_a[i]);
                r_v[i] <= (CW+1)'(i_p[i]) - (CW+1)'(i_a[i]);
            end
            r_dot  <= '0;
            r_len  <= '0;
            r_dist <= '0;
            r_sat  <= 1'b0;
        end

        // Multiplier stage and its tag.
        r_prod <= mul_a * mul_b;
        r_ph   <= ph;
        r_pk   <= c;
        r_pneg <= r_d[c][CW];
        r_pa   <= i_a[c];

        // Fold a finished product into its accumulator.
        if (r_pv) begin
            unique case (r_ph)
                PH_DOT: r_dot <= r_dot + DW'(r_prod);
                PH_LEN: r_len <= r_len + DW'(r_prod);
                PH_PRJ: r_prj[r_pk] <= CW'(psum);
                default: begin
                    r_dist <= dsum[DIST_W-1:0];
                    r_sat  <= r_sat | dsum[DIST_W];
                end
            endcase
        end

        // Restoring division of the dot product by the squared length.
        if (r_state == SG_CHK) begin
            r_rem <= {1'b0, r_dot};
            r_q   <= '0;
        end else if (r_state == SG_DIV) begin
            r_rem <= div_ge ? rem_s - den : rem_s;
            r_q   <= {r_q[QW-2:0], div_ge};
        end
    end

    assign o_stat.busy = (r_state != SG_IDLE);
    assign o_stat.done = (r_state == SG_DONE);
    assign o_stat.hit  = r_hit;
    assign o_dist      = r_sat ? '1 : r_dist;
    assign o_prj       = r_prj;

endmodule

// File: rtl/core/polyline_point_snap_core.sv
// Top level of the polyline point snap core: controller, config registers,
// best-match tracking and output register. Depends on pps_pkg,
// pps_path_mem, pps_seg_unit and polyline_point_snap_core_defines.svh.
//
// Usage: the request channel (i_req_valid / o_req_ready / i_req) carries
// two kinds of transaction. A write stores one point in the path slot given
// by point_index; slots at or above MAX_POINTS are dropped. A query returns
// one response transaction on o_rsp_valid / i_rsp_ready / o_rsp with the
// nearest projection within the snap width. A query walks the stored
// segments one at a time through the bit-serial divider and the shared
// multiplier in the segment unit; a segment rejected by the range checks
// skips the division and the projection. Fewer than two points give a
// not-found response. The response sits in an output register, so the
// next request is accepted while it waits; a finished query waits only
// when that register is still full. Configuration writes on i_cfg_we are
// registered; the snap width reaches the comparison through r_lim2, its
// registered square. Synchronous reset clears the config registers and the
// control state; the path store keeps no reset value and must be written
// before a query reads it.
`include "polyline_point_snap_core_defines.svh"

module polyline_point_snap_core
    import pps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_req                 i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_data
);

    localparam int CW    = COORD_BITS;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int DATAW = 3 * CW;
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int CMPW  = (NW > PC_W) ? NW : PC_W;
    localparam int IW    = (NW > IDX_W) ? NW : IDX_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RDA  = 5'b00010,
        S_RDB  = 5'b00100,
        S_SEG  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CFG_DW-1:0] r_snap;
    logic [PC_W-1:0] r_pc;
    logic [2*CFG_DW-1:0] r_lim2;
    logic signed [CW-1:0] r_p [3];
    logic signed [CW-1:0] r_a [3];
    logic signed [CW-1:0] r_b [3];
    logic signed [CW-1:0] r_bx [3];
    logic [AW-1:0] r_seg;
    logic r_found;
    logic [DIST_W-1:0] r_best;
    logic r_out_v;
    t_rsp r_out;

    logic in_acc, out_free;
    logic [CMPW-1:0] pc_ext, n_eff, next_ix;
    logic few, more, take;
    logic [IW-1:0] idx_ext;
    logic signed [CW-1:0] q_pt [3];
    logic signed [CW-1:0] rd_pt [3];

    logic mem_we, mem_re;
    logic [AW-1:0] mem_raddr;
    logic [DATAW-1:0] mem_wdata, mem_rdata;

    t_seg_stat seg_stat;
    logic [DIST_W-1:0] seg_dist;
    logic signed [CW-1:0] seg_prj [3];

    // Handshake and segment bookkeeping.
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        in_acc      = i_req_valid && o_req_ready;
        out_free    = !r_out_v || i_rsp_ready;
        pc_ext      = CMPW'(r_pc);
        n_eff       = (pc_ext > CMPW'(MAX_POINTS)) ? CMPW'(MAX_POINTS) : pc_ext;
        few         = (n_eff < CMPW'(2));
        next_ix     = CMPW'(r_seg) + CMPW'(2);
        more        = (next_ix < n_eff);
        idx_ext     = IW'(i_req.point_index);
        take        = seg_stat.hit && (seg_dist <= DIST_W'(r_lim2)) &&
                      (!r_found || (seg_dist <= r_best));
    end

    // Unpack coordinates to the internal width, and store words back.
    always_comb begin
        q_pt[0] = i_req.coord_x[CW-1:0];
        q_pt[1] = i_req.coord_y[CW-1:0];
        q_pt[2] = i_req.coord_z[CW-1:0];
        for (int i = 0; i < 3; i++) begin
            rd_pt[i] = mem_rdata[i*CW +: CW];
        end
        mem_wdata = {q_pt[2], q_pt[1], q_pt[0]};
    end

    // Store port control.
    always_comb begin
        mem_we    = in_acc && (i_req.req_type == REQ_WRITE) &&
                    (idx_ext < IW'(MAX_POINTS));
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (r_state)
            S_IDLE: mem_re = in_acc && (i_req.req_type == REQ_QUERY) && !few;
            S_RDA: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(1);
            end
            S_SEG: begin
                mem_re    = seg_stat.done && more;
                mem_raddr = next_ix[AW-1:0];
            end
            default: mem_re = 1'b0;
        endcase
    end

    // Controller transitions.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_req.req_type == REQ_QUERY)) begin
                    n_state = few ? S_FIN : S_RDA;
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: n_state = S_SEG;
            S_SEG: begin
                if (seg_stat.done) begin
                    n_state = more ? S_RDB : S_FIN;
                end
            end
            S_FIN: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_snap  <= '0;
            r_pc    <= '0;
            r_lim2  <= '0;
            r_out_v <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lim2  <= r_snap * r_snap;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SNAP_WIDTH:  r_snap <= i_cfg_data;
                    CFG_POINT_COUNT: r_pc   <= i_cfg_data[PC_W-1:0];
                    default:         r_snap <= r_snap;
                endcase
            end
            if (r_state == S_IDLE) begin
                r_found <= 1'b0;
            end else if ((r_state == S_SEG) && seg_stat.done && take) begin
                r_found <= 1'b1;
            end
            if ((r_state == S_FIN) && out_free) begin
                r_out_v <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Query point, segment ends, best match and the response register.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p   <= q_pt;
            r_seg <= '0;
        end
        if (r_state == S_RDA) begin
            r_a <= rd_pt;
        end
        if (r_state == S_RDB) begin
            r_b <= rd_pt;
        end
        if ((r_state == S_SEG) && seg_stat.done) begin
            r_a   <= r_b;
            r_seg <= r_seg + AW'(1);
            if (take) begin
                r_best <= seg_dist;
                r_bx   <= seg_prj;
            end
        end
        if ((r_state == S_FIN) && out_free) begin
            r_out.found       <= r_found;
            r_out.snap_x      <= r_found ? FLD_W'(r_bx[0]) : '0;
            r_out.snap_y      <= r_found ? FLD_W'(r_bx[1]) : '0;
            r_out.snap_z      <= r_found ? FLD_W'(r_bx[2]) : '0;
            r_out.distance_sq <= r_found ? r_best : '0;
        end
    end

    assign o_rsp_valid = r_out_v;
    assign o_rsp       = r_out;

    pps_path_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW),
        .DATAW (DATAW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pps_seg_unit #(
        .CW (CW)
    ) u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RDB),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_p     (r_p),
        .o_stat  (seg_stat),
        .o_dist  (seg_dist),
        .o_prj   (seg_prj)
    );

    // The segment unit reports completion only while the controller waits.
    `PPS_ASSERT_IMP(a_done_in_seg, seg_stat.done, r_state == S_SEG,
        "segment result outside the segment wait state")
    // A new segment starts only on an idle segment unit.
    `PPS_ASSERT_IMP(a_start_idle, r_state == S_RDB, !seg_stat.busy,
        "segment started while the unit is busy")
    // A miss carries an all-zero point and distance.
    `PPS_ASSERT_IMP(a_miss_zero, o_rsp_valid && !o_rsp.found,
        (o_rsp.distance_sq == '0) && (o_rsp.snap_x == '0) &&
        (o_rsp.snap_y == '0) && (o_rsp.snap_z == '0),
        "miss response with nonzero payload")
    // A hit never exceeds the squared snap width.
    `PPS_ASSERT_IMP(a_hit_limit, o_rsp_valid && o_rsp.found,
        o_rsp.distance_sq <= DIST_W'(r_lim2), "hit beyond the snap width")
    // An accepted query holds off the request channel in the next cycle.
    `PPS_ASSERT_NXT(a_query_busy, in_acc && (i_req.req_type == REQ_QUERY),
        !o_req_ready, "request accepted during a query")

endmodule
